@@ sv/ntclut_pkg.sv @@
// ----------------------------------------------------------------------------
// ntclut_pkg
// Shared constants and types for the thermistor ADC lookup unit.
// ----------------------------------------------------------------------------
package ntclut_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   localparam int ADC_W       = 12;
   localparam int TEMP_W      = 8;
   localparam int COUNT_W     = 16;
   localparam int ENTRY_IDX_W = 5;
   localparam int USED_W      = 6;
   localparam int FAULT_W     = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // register map
   localparam logic [CSR_INDEX_W-1:0] CSR_OPEN_THRESHOLD  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHORT_THRESHOLD = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAULT_LIMIT     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVALID_CODE    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENTRIES_USED    = 3'd4;

   // fault codes
   localparam logic [FAULT_W-1:0] FAULT_NONE  = 2'd0;
   localparam logic [FAULT_W-1:0] FAULT_OPEN  = 2'd1;
   localparam logic [FAULT_W-1:0] FAULT_SHORT = 2'd2;

   // table write broadcast to every cell
   typedef struct packed {
      logic              enable;
      logic [IDX_W-1:0]  index;
      logic [ADC_W-1:0]  adc;
      logic [TEMP_W-1:0] temp;
   } wr_type;

   // search token handed from cell to cell
   typedef struct packed {
      logic              valid;
      logic [ADC_W-1:0]  sample;
      logic              gt_first;   // sample above breakpoint 1
      logic              le_last;    // sample at or below last used breakpoint
      logic [TEMP_W-1:0] last_temp;
      logic              hit;
      logic [TEMP_W-1:0] hit_temp;
      logic              prev_ge;    // previous breakpoint >= sample
      logic [TEMP_W-1:0] prev_temp;
   } pkt_type;

endpackage

@@ sv/ntc_adc_to_temperature_lookup_unit.sv @@
// ----------------------------------------------------------------------------
// ntc_adc_to_temperature_lookup_unit
// Thermistor ADC to temperature code with open and short detection.
// ----------------------------------------------------------------------------
// A table load gives no result. A fault sample (open or short) needs no walk:
// its result is registered from the transfer itself, and the unit stays ready
// for the next item unless that result has to wait in the holding register. A
// normal sample is carried down a chain of TABLE_DEPTH cells, one cell per
// cycle, each cell holding one breakpoint and temperature; the next item can
// transfer only once its result has left the chain. A finished result waits in
// the output register while the next item is taken; a second finished result
// waits in a holding register and holds off the input until the output
// register frees.
module ntc_adc_to_temperature_lookup_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_mode,
   input  logic [ntclut_pkg::ADC_W-1:0]        req_sample,
   input  logic [ntclut_pkg::ENTRY_IDX_W-1:0]  req_entry_index,
   input  logic [ntclut_pkg::ADC_W-1:0]        req_entry_adc,
   input  logic [ntclut_pkg::TEMP_W-1:0]       req_entry_temp,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [ntclut_pkg::TEMP_W-1:0]       rsp_temperature,
   output logic [ntclut_pkg::FAULT_W-1:0]      rsp_fault,
   input  logic                                csr_write_enable,
   input  logic [ntclut_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ntclut_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WALK = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   // configuration
   logic [ntclut_pkg::ADC_W-1:0]   open_th_ff;
   logic [ntclut_pkg::ADC_W-1:0]   short_th_ff;
   logic [ntclut_pkg::COUNT_W-1:0] fault_limit_ff;
   logic [ntclut_pkg::TEMP_W-1:0]  invalid_code_ff;
   logic [ntclut_pkg::USED_W-1:0]  entries_used_ff;

   logic [1:0]                     state_ff, state_in;
   logic [ntclut_pkg::COUNT_W-1:0] fault_count_ff, fault_count_in;
   logic [ntclut_pkg::TEMP_W-1:0]  temp0_ff;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [ntclut_pkg::TEMP_W-1:0]  rsp_temp_ff, rsp_temp_in;
   logic [ntclut_pkg::FAULT_W-1:0] rsp_fault_ff, rsp_fault_in;
   logic [ntclut_pkg::TEMP_W-1:0]  pend_temp_ff, pend_temp_in;
   logic [ntclut_pkg::FAULT_W-1:0] pend_fault_ff, pend_fault_in;

   logic                           req_xfer;
   logic                           out_free;
   logic                           is_open;
   logic                           is_short;
   logic                           is_fault;
   logic [ntclut_pkg::IDX_W-1:0]   last_index;
   logic                           res_valid;
   logic [ntclut_pkg::TEMP_W-1:0]  res_temp;
   logic [ntclut_pkg::FAULT_W-1:0] res_fault;
   logic [ntclut_pkg::TEMP_W-1:0]  walk_temp;

   ntclut_pkg::wr_type             wr;
   ntclut_pkg::pkt_type            inject;
   ntclut_pkg::pkt_type            chain [ntclut_pkg::TABLE_DEPTH+1];

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign is_open  = (req_sample >= open_th_ff);
   assign is_short = (req_sample <= short_th_ff);
   assign is_fault = is_open || is_short;

   // clamp entries_used to 3 .. TABLE_DEPTH, kept as the last used index
   always_comb begin
      if (32'(entries_used_ff) < 32'd3) begin
         last_index = ntclut_pkg::IDX_W'(2);
      end else if (32'(entries_used_ff) > 32'(ntclut_pkg::TABLE_DEPTH)) begin
         last_index = ntclut_pkg::IDX_W'(ntclut_pkg::TABLE_DEPTH - 1);
      end else begin
         last_index = ntclut_pkg::IDX_W'(32'(entries_used_ff) - 32'd1);
      end
   end

   always_comb begin
      wr.enable = req_xfer && req_mode &&
                  (32'(req_entry_index) < 32'(ntclut_pkg::TABLE_DEPTH));
      wr.index  = ntclut_pkg::IDX_W'(req_entry_index);
      wr.adc    = req_entry_adc;
      wr.temp   = req_entry_temp;
   end

   always_comb begin
      inject        = '0;
      inject.valid  = req_xfer && !req_mode && !is_fault;
      inject.sample = req_sample;
   end

   assign chain[0] = inject;

   for (genvar j = 0; j < ntclut_pkg::TABLE_DEPTH; j++) begin : g_cell
      ntclut_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .my_index   (ntclut_pkg::IDX_W'(j)),
         .last_index (last_index),
         .wr         (wr),
         .pkt_i      (chain[j]),
         .pkt_o      (chain[j+1])
      );
   end

   // priority: above breakpoint 1, at/below last, first interval hit, else entry 0
   always_comb begin
      priority if (chain[ntclut_pkg::TABLE_DEPTH].gt_first) begin
         walk_temp = temp0_ff;
      end else if (chain[ntclut_pkg::TABLE_DEPTH].le_last) begin
         walk_temp = chain[ntclut_pkg::TABLE_DEPTH].last_temp;
      end else if (chain[ntclut_pkg::TABLE_DEPTH].hit) begin
         walk_temp = chain[ntclut_pkg::TABLE_DEPTH].hit_temp;
      end else begin
         walk_temp = temp0_ff;
      end
   end

   always_comb begin
      fault_count_in = fault_count_ff;
      res_valid      = 1'b0;
      res_temp       = walk_temp;
      res_fault      = ntclut_pkg::FAULT_NONE;
      if (req_xfer && !req_mode) begin
         if (is_fault) begin
            res_valid = 1'b1;
            res_fault = is_open ? ntclut_pkg::FAULT_OPEN : ntclut_pkg::FAULT_SHORT;
            if (fault_count_ff > fault_limit_ff) begin
               res_temp = invalid_code_ff;
            end else begin
               res_temp = temp0_ff;
               if (fault_count_ff != '1) begin
                  fault_count_in = fault_count_ff + ntclut_pkg::COUNT_W'(1);
               end
            end
         end else begin
            fault_count_in = '0;
         end
      end else if (chain[ntclut_pkg::TABLE_DEPTH].valid) begin
         res_valid = 1'b1;
      end
   end

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_temp_in   = rsp_temp_ff;
      rsp_fault_in  = rsp_fault_ff;
      pend_temp_in  = pend_temp_ff;
      pend_fault_in = pend_fault_ff;

      if (res_valid) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_temp_in  = res_temp;
            rsp_fault_in = res_fault;
         end else begin
            pend_temp_in  = res_temp;
            pend_fault_in = res_fault;
         end
      end else if ((state_ff == ST_HOLD) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_temp_in  = pend_temp_ff;
         rsp_fault_in = pend_fault_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer && !req_mode) begin
               if (!is_fault) begin
                  state_in = ST_WALK;
               end else if (!out_free) begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_WALK: begin
            if (chain[ntclut_pkg::TABLE_DEPTH].valid) begin
               state_in = out_free ? ST_IDLE : ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_th_ff      <= 12'd4000;
         short_th_ff     <= 12'd100;
         fault_limit_ff  <= 16'd100;
         invalid_code_ff <= 8'd255;
         entries_used_ff <= 6'd32;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            ntclut_pkg::CSR_OPEN_THRESHOLD:  open_th_ff      <= csr_wdata[11:0];
            ntclut_pkg::CSR_SHORT_THRESHOLD: short_th_ff     <= csr_wdata[11:0];
            ntclut_pkg::CSR_FAULT_LIMIT:     fault_limit_ff  <= csr_wdata;
            ntclut_pkg::CSR_INVALID_CODE:    invalid_code_ff <= csr_wdata[7:0];
            ntclut_pkg::CSR_ENTRIES_USED:    entries_used_ff <= csr_wdata[5:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         fault_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         fault_count_ff <= fault_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_temp_ff   <= rsp_temp_in;
      rsp_fault_ff  <= rsp_fault_in;
      pend_temp_ff  <= pend_temp_in;
      pend_fault_ff <= pend_fault_in;
      // entry 0 mirrored here for fault results and fallbacks
      if (wr.enable && (wr.index == '0)) begin
         temp0_ff <= req_entry_temp;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_temperature = rsp_temp_ff;
   assign rsp_fault       = rsp_fault_ff;

   // no token at the chain tail while new items are taken
   a_idle_chain_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !chain[ntclut_pkg::TABLE_DEPTH].valid)
      else $error("chain token present while idle");

   // chain tail only arrives during a walk
   a_tail_in_walk: assert property (@(posedge clock) disable iff (reset)
      chain[ntclut_pkg::TABLE_DEPTH].valid |-> (state_ff == ST_WALK))
      else $error("chain tail outside walk");

   // holding a result implies the output register is occupied
   a_hold_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HOLD) |-> rsp_valid_ff)
      else $error("hold state with empty output register");

   // a normal sample clears the fault counter
   a_count_clear: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && !req_mode && !is_fault) |=> (fault_count_ff == '0))
      else $error("fault counter not cleared");

   // a walk result is never a fault
   a_walk_no_fault: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_WALK) && chain[ntclut_pkg::TABLE_DEPTH].valid && out_free)
      |=> (rsp_valid_ff && (rsp_fault_ff == ntclut_pkg::FAULT_NONE)))
      else $error("walk result flagged as fault");

endmodule

@@ sv/ntclut_cell.sv @@
// ----------------------------------------------------------------------------
// ntclut_cell
// One table entry plus one stage of the search chain.
// ----------------------------------------------------------------------------
module ntclut_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [ntclut_pkg::IDX_W-1:0]  my_index,
   input  logic [ntclut_pkg::IDX_W-1:0]  last_index,
   input  ntclut_pkg::wr_type            wr,
   input  ntclut_pkg::pkt_type           pkt_i,
   output ntclut_pkg::pkt_type           pkt_o
);

   logic [ntclut_pkg::ADC_W-1:0]  adc_ff;
   logic [ntclut_pkg::TEMP_W-1:0] temp_ff;
   ntclut_pkg::pkt_type           pkt_ff;
   ntclut_pkg::pkt_type           pkt_in;

   logic is_first;
   logic is_last;
   logic in_range;

   assign is_first = (my_index == ntclut_pkg::IDX_W'(1));
   assign is_last  = (my_index == last_index);
   // interval checks apply to cells 2 .. last
   assign in_range = (32'(my_index) >= 32'd2) && (my_index <= last_index);

   always_comb begin
      pkt_in = pkt_i;
      if (is_first) begin
         pkt_in.gt_first = (pkt_i.sample > adc_ff);
      end
      if (is_last) begin
         pkt_in.le_last   = (pkt_i.sample <= adc_ff);
         pkt_in.last_temp = temp_ff;
      end
      if (in_range && !pkt_i.hit && pkt_i.prev_ge && (adc_ff < pkt_i.sample)) begin
         pkt_in.hit      = 1'b1;
         pkt_in.hit_temp = pkt_i.prev_temp;
      end
      pkt_in.prev_ge   = (adc_ff >= pkt_i.sample);
      pkt_in.prev_temp = temp_ff;
   end

   always_ff @(posedge clock) begin
      if (wr.enable && (wr.index == my_index)) begin
         adc_ff  <= wr.adc;
         temp_ff <= wr.temp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pkt_ff <= '0;
      end else begin
         pkt_ff <= pkt_in;
      end
   end

   assign pkt_o = pkt_ff;

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the thermistor ADC lookup unit against a cycle-free prediction.
// A queue of table loads and conversions feeds a valid/ready driver. A monitor
// predicts each transfer's reading and compares the readings that come back.
// The run covers several register settings, including a run of fault samples
// with no idling that pushes the fault counter past its limit.
// ----------------------------------------------------------------------------
module testbench;

   localparam logic MODE_CONVERT  = 1'b0;
   localparam logic MODE_LOAD     = 1'b1;
   localparam int   SETTLE_CYCLES = ntclut_pkg::TABLE_DEPTH + 8;
   localparam int   STALL_LIMIT   = 4000;
   localparam int   NUM_SETTINGS  = 10;
   localparam int   PHASE_ITEMS   = 12;

   typedef struct packed {
      logic                               mode;
      logic [ntclut_pkg::ADC_W-1:0]       sample;
      logic [ntclut_pkg::ENTRY_IDX_W-1:0] entry_index;
      logic [ntclut_pkg::ADC_W-1:0]       entry_adc;
      logic [ntclut_pkg::TEMP_W-1:0]      entry_temp;
   } req_item_type;

   typedef struct packed {
      logic [ntclut_pkg::TEMP_W-1:0]  temperature;
      logic [ntclut_pkg::FAULT_W-1:0] fault;
   } reading_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic                               req_mode = 1'b0;
   logic [ntclut_pkg::ADC_W-1:0]       req_sample = '0;
   logic [ntclut_pkg::ENTRY_IDX_W-1:0] req_entry_index = '0;
   logic [ntclut_pkg::ADC_W-1:0]       req_entry_adc = '0;
   logic [ntclut_pkg::TEMP_W-1:0]      req_entry_temp = '0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic [ntclut_pkg::TEMP_W-1:0]      rsp_temperature;
   logic [ntclut_pkg::FAULT_W-1:0]     rsp_fault;
   logic                               csr_write_enable = 1'b0;
   logic [ntclut_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [ntclut_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   ntc_adc_to_temperature_lookup_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_sample       (req_sample),
      .req_entry_index  (req_entry_index),
      .req_entry_adc    (req_entry_adc),
      .req_entry_temp   (req_entry_temp),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_temperature  (rsp_temperature),
      .rsp_fault        (rsp_fault),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor copy of the block
   logic [ntclut_pkg::ADC_W-1:0]   adc_tab [ntclut_pkg::TABLE_DEPTH];
   logic [ntclut_pkg::TEMP_W-1:0]  temp_tab [ntclut_pkg::TABLE_DEPTH];
   logic [ntclut_pkg::COUNT_W-1:0] fault_cnt = '0;
   logic [ntclut_pkg::ADC_W-1:0]   cfg_open = 12'd4000;
   logic [ntclut_pkg::ADC_W-1:0]   cfg_short = 12'd100;
   logic [ntclut_pkg::COUNT_W-1:0] cfg_limit = 16'd100;
   logic [ntclut_pkg::TEMP_W-1:0]  cfg_invalid = 8'd255;
   logic [ntclut_pkg::USED_W-1:0]  cfg_used = 6'd32;

   // breakpoints as queued, used to aim samples
   logic [ntclut_pkg::ADC_W-1:0]   plan_adc [ntclut_pkg::TABLE_DEPTH];

   req_item_type pending_items[$];
   reading_type  expected_readings[$];
   req_item_type drive_item;
   reading_type  want;

   int  req_issued = 0;
   int  req_xfers = 0;
   bit  calm = 1'b0;
   int  mismatches = 0;
   int  n_conversions = 0;
   int  n_loads = 0;
   int  n_faults = 0;
   int  n_invalid = 0;
   int  n_checked = 0;
   int  n_settings = 0;
   int  stall_cycles = 0;

   int set_open  [NUM_SETTINGS] = '{4000, 4095, 3000, 2048, 0, 3500, 3900, 4095, 1, 3800};
   int set_short [NUM_SETTINGS] = '{100, 0, 1000, 2047, 4095, 500, 50, 4095, 0, 300};
   int set_limit [NUM_SETTINGS] = '{100, 0, 5, 2, 3, 65534, 10, 1, 20, 100};
   int set_inval [NUM_SETTINGS] = '{255, 0, 128, 200, 1, 77, 255, 9, 0, 180};
   int set_used  [NUM_SETTINGS] = '{32, 3, 16, 32, 8, 2, 33, 63, 5, 24};

   function automatic int used_entries();
      int n;
      n = int'(cfg_used);
      if (n < 3) n = 3;
      if (n > ntclut_pkg::TABLE_DEPTH) n = ntclut_pkg::TABLE_DEPTH;
      return n;
   endfunction

   function automatic logic [ntclut_pkg::TEMP_W-1:0] table_temp_for(
      input logic [ntclut_pkg::ADC_W-1:0] s);
      int n;
      n = used_entries();
      if (s > adc_tab[1]) return temp_tab[0];
      if (s <= adc_tab[n-1]) return temp_tab[n-1];
      for (int k = 1; k + 1 < n; k++) begin
         if (adc_tab[k] >= s && adc_tab[k+1] < s) return temp_tab[k];
      end
      return temp_tab[0];
   endfunction

   task automatic predict_reading(input req_item_type it);
      reading_type r;
      if (it.mode == MODE_LOAD) begin
         adc_tab[it.entry_index]  = it.entry_adc;
         temp_tab[it.entry_index] = it.entry_temp;
         n_loads++;
      end else begin
         r.fault       = ntclut_pkg::FAULT_NONE;
         r.temperature = temp_tab[0];
         if (it.sample >= cfg_open || it.sample <= cfg_short) begin
            r.fault = (it.sample >= cfg_open) ? ntclut_pkg::FAULT_OPEN
                                              : ntclut_pkg::FAULT_SHORT;
            if (fault_cnt > cfg_limit) begin
               r.temperature = cfg_invalid;
               n_invalid++;
            end else if (fault_cnt != {ntclut_pkg::COUNT_W{1'b1}}) begin
               fault_cnt = fault_cnt + ntclut_pkg::COUNT_W'(1);
            end
            n_faults++;
         end else begin
            fault_cnt     = '0;
            r.temperature = table_temp_for(it.sample);
         end
         expected_readings.push_back(r);
         n_conversions++;
      end
   endtask

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("[%0t] MISMATCH: %s", $time, msg);
   endtask

   // driver: new payload only after the previous one transferred
   always @(negedge clock) begin
      if (!(req_valid && req_xfers < req_issued)) begin
         if (pending_items.size() != 0 && (calm || $urandom_range(99) >= 26)) begin
            drive_item = pending_items.pop_front();
            req_valid       <= 1'b1;
            req_mode        <= drive_item.mode;
            req_sample      <= drive_item.sample;
            req_entry_index <= drive_item.entry_index;
            req_entry_adc   <= drive_item.entry_adc;
            req_entry_temp  <= drive_item.entry_temp;
            req_issued++;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= calm || ($urandom_range(99) >= 26);
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_reading('{req_mode, req_sample, req_entry_index,
                              req_entry_adc, req_entry_temp});
            req_xfers++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_readings.size() == 0) begin
               report_mismatch($sformatf("unexpected reading temperature %0d fault %0d",
                                         rsp_temperature, rsp_fault));
            end else begin
               want = expected_readings.pop_front();
               if (rsp_temperature !== want.temperature)
                  report_mismatch($sformatf("temperature %0d, predicted %0d",
                                            rsp_temperature, want.temperature));
               if (rsp_fault !== want.fault)
                  report_mismatch($sformatf("fault %0d, predicted %0d",
                                            rsp_fault, want.fault));
               n_checked++;
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles, %0d readings outstanding",
                  stall_cycles, expected_readings.size());
         $display("ntc_adc_to_temperature_lookup_unit: mismatch");
         $finish;
      end
   end

   task automatic queue_load(input int idx, input int adc, input int temp);
      req_item_type it;
      it.mode        = MODE_LOAD;
      it.sample      = ntclut_pkg::ADC_W'($urandom_range(4095));
      it.entry_index = ntclut_pkg::ENTRY_IDX_W'(idx);
      it.entry_adc   = ntclut_pkg::ADC_W'(adc);
      it.entry_temp  = ntclut_pkg::TEMP_W'(temp);
      plan_adc[idx]  = ntclut_pkg::ADC_W'(adc);
      pending_items.push_back(it);
   endtask

   task automatic queue_convert(input int s);
      req_item_type it;
      it.mode        = MODE_CONVERT;
      it.sample      = ntclut_pkg::ADC_W'(s);
      it.entry_index = ntclut_pkg::ENTRY_IDX_W'($urandom_range(ntclut_pkg::TABLE_DEPTH - 1));
      it.entry_adc   = ntclut_pkg::ADC_W'($urandom_range(4095));
      it.entry_temp  = ntclut_pkg::TEMP_W'($urandom_range(255));
      pending_items.push_back(it);
   endtask

   task automatic queue_table(input bit sorted);
      int vals[$];
      int order[$];
      for (int i = 0; i < ntclut_pkg::TABLE_DEPTH; i++) begin
         vals.push_back($urandom_range(4095));
         order.push_back(i);
      end
      if (sorted) vals.rsort();
      order.shuffle();
      foreach (order[j]) queue_load(order[j], vals[order[j]], $urandom_range(255));
   endtask

   function automatic int fault_sample();
      if ($urandom_range(1)) return $urandom_range(4095, int'(cfg_open));
      return $urandom_range(int'(cfg_short), 0);
   endfunction

   // half of the picks land near breakpoints and thresholds, where the decisions flip
   function automatic int pick_sample();
      int r;
      int v;
      r = $urandom_range(99);
      if (r < 35) begin
         v = int'(plan_adc[$urandom_range(used_entries() - 1)]) + int'($urandom_range(2)) - 1;
      end else if (r < 50) begin
         case ($urandom_range(3))
            0: v = int'(cfg_open);
            1: v = int'(cfg_open) + int'($urandom_range(40));
            2: v = int'(cfg_short);
            default: v = int'(cfg_short) - int'($urandom_range(40));
         endcase
      end else if (r < 58) begin
         v = $urandom_range(1) ? 4095 : 0;
      end else begin
         v = $urandom_range(4095);
      end
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return v;
   endfunction

   task automatic write_csr(input logic [ntclut_pkg::CSR_INDEX_W-1:0] idx, input int data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= data[ntclut_pkg::CSR_DATA_W-1:0];
      case (idx)
         ntclut_pkg::CSR_OPEN_THRESHOLD:  cfg_open    = data[ntclut_pkg::ADC_W-1:0];
         ntclut_pkg::CSR_SHORT_THRESHOLD: cfg_short   = data[ntclut_pkg::ADC_W-1:0];
         ntclut_pkg::CSR_FAULT_LIMIT:     cfg_limit   = data[ntclut_pkg::COUNT_W-1:0];
         ntclut_pkg::CSR_INVALID_CODE:    cfg_invalid = data[ntclut_pkg::TEMP_W-1:0];
         ntclut_pkg::CSR_ENTRIES_USED:    cfg_used    = data[ntclut_pkg::USED_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic apply_setting(input int o, input int s, input int l, input int i,
                                input int u);
      write_csr(ntclut_pkg::CSR_OPEN_THRESHOLD, o);
      write_csr(ntclut_pkg::CSR_SHORT_THRESHOLD, s);
      write_csr(ntclut_pkg::CSR_FAULT_LIMIT, l);
      write_csr(ntclut_pkg::CSR_INVALID_CODE, i);
      write_csr(ntclut_pkg::CSR_ENTRIES_USED, u);
      n_settings++;
   endtask

   // everything queued has transferred and every reading has come back
   task automatic wait_quiet();
      while (pending_items.size() != 0 || (req_valid && req_xfers < req_issued) ||
             expected_readings.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      bit burst_done;
      int r;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // fixed descending table, reset register values
      for (int i = 0; i < ntclut_pkg::TABLE_DEPTH; i++)
         queue_load(i, 3800 - 110 * i, (i == 0) ? 255 : 248 - 8 * i);
      queue_convert(4095);
      queue_convert(4000);
      queue_convert(3999);
      queue_convert(0);
      queue_convert(100);
      queue_convert(101);
      queue_convert(3691);    // just above breakpoint 1
      queue_convert(3690);
      queue_convert(390);     // last breakpoint
      queue_convert(2000);
      wait_quiet();

      // fault persistence: counter passes a limit of one, then a clear
      write_csr(ntclut_pkg::CSR_FAULT_LIMIT, 1);
      write_csr(ntclut_pkg::CSR_INVALID_CODE, 8'h5A);
      queue_convert(4095);
      queue_convert(0);
      queue_convert(4095);
      queue_convert(0);
      queue_convert(2000);
      queue_convert(4095);
      queue_convert(1000);
      wait_quiet();

      // open and short overlap: open wins
      write_csr(ntclut_pkg::CSR_OPEN_THRESHOLD, 50);
      write_csr(ntclut_pkg::CSR_SHORT_THRESHOLD, 3000);
      queue_convert(2000);
      queue_convert(40);
      queue_convert(3500);
      wait_quiet();

      // thresholds at the extremes, table size below and above range
      write_csr(ntclut_pkg::CSR_OPEN_THRESHOLD, 4095);
      write_csr(ntclut_pkg::CSR_SHORT_THRESHOLD, 0);
      write_csr(ntclut_pkg::CSR_ENTRIES_USED, 0);
      queue_convert(4094);
      queue_convert(1);
      queue_convert(3500);
      wait_quiet();
      write_csr(ntclut_pkg::CSR_ENTRIES_USED, 63);
      queue_convert(390);
      queue_convert(1000);
      wait_quiet();

      // fault run past the limit, then a clear, no idling
      apply_setting(4000, 100, 20, 8'h33, 32);
      calm = 1'b1;
      repeat (24) queue_convert(fault_sample());
      queue_convert(2000);
      repeat (5) queue_convert(pick_sample());
      wait_quiet();
      calm = 1'b0;

      for (int p = 0; p < NUM_SETTINGS; p++) begin
         apply_setting(set_open[p], set_short[p], set_limit[p], set_inval[p], set_used[p]);
         if ($urandom_range(99) < 70) queue_table($urandom_range(99) < 80);
         burst_done = 1'b0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            r = $urandom_range(99);
            if (r < 12) begin
               queue_load($urandom_range(ntclut_pkg::TABLE_DEPTH - 1), $urandom_range(4095),
                          $urandom_range(255));
            end else if (r < 20 && !burst_done && cfg_limit <= 30) begin
               repeat (int'(cfg_limit) + 2) queue_convert(fault_sample());
               burst_done = 1'b1;
            end else begin
               queue_convert(pick_sample());
            end
         end
         wait_quiet();
      end

      $display("run covered %0d conversions (%0d faults, %0d invalid codes) and %0d table loads",
               n_conversions, n_faults, n_invalid, n_loads);
      $display("over %0d register settings; %0d readings checked", n_settings, n_checked);
      if (mismatches == 0) begin
         $display("ntc_adc_to_temperature_lookup_unit: match");
      end else begin
         $display("ntc_adc_to_temperature_lookup_unit: mismatch");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/ntclut_pkg.sv
sv/ntclut_cell.sv
sv/ntc_adc_to_temperature_lookup_unit.sv
dv/testbench.sv
